[hw/rtl/ptagg_pkg.sv]
// ----------------------------------------------------------------------------
// Power telemetry aggregator package
// Shared payload types, register indexes and constants of the aggregator.
// ----------------------------------------------------------------------------
package ptagg_pkg;

    // Field widths.
    localparam int TIME_W   = 40;
    localparam int UTIL_W   = 16;
    localparam int CNT_W    = 16;
    localparam int SUM_W    = 32;
    localparam int WORD_W   = 32;
    localparam int DICE_W   = 3;
    localparam int MINUTE_W = 35;

    // Shared divider geometry: dividend width and step counter width.
    localparam int DIV_W      = 32;
    localparam int DIV_STEP_W = 6;

    // Divider step count: one step per bit of the sum.
    localparam logic [DIV_STEP_W-1:0] AVG_STEPS = 6'd32;

    // Minute number by reciprocal multiplication:
    // minute = ((seconds >> 2) * MIN_RECIP) >> RECIP_SHIFT, exact for 40-bit times.
    // The multiply runs in two steps, high part of the constant first.
    localparam int TQ_W        = TIME_W - 2;
    localparam int RECIP_W     = 39;
    localparam int RECIP_LO_W  = 19;
    localparam int RECIP_HI_W  = RECIP_W - RECIP_LO_W;
    localparam int MUL_W       = TQ_W + RECIP_HI_W;
    localparam int PROD_W      = TQ_W + RECIP_W;
    localparam int RECIP_SHIFT = PROD_W - MINUTE_W;
    localparam logic [RECIP_W-1:0]    MIN_RECIP = 39'd293203100741;
    localparam logic [RECIP_HI_W-1:0] RECIP_HI  = MIN_RECIP[RECIP_W-1:RECIP_LO_W];
    localparam logic [RECIP_HI_W-1:0] RECIP_LO  = {1'b0, MIN_RECIP[RECIP_LO_W-1:0]};

    localparam logic [UTIL_W-1:0] SEC_PER_MIN = 16'd60;
    localparam logic [UTIL_W-1:0] UTIL_SAT    = 16'hFFFF;
    localparam logic [CNT_W-1:0]  CNT_SAT     = 16'hFFFF;
    localparam logic [SUM_W-1:0]  SUM_SAT     = 32'hFFFF_FFFF;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_DICE_IN_USE    = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_VALID_BIPS = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_SAMPLES    = 8'd2;
    localparam int CFG_DATA_W = 16;

    // Configuration reset values.
    localparam logic [DICE_W-1:0] RST_DICE_IN_USE    = 3'd2;
    localparam logic [UTIL_W-1:0] RST_MAX_VALID_BIPS = 16'd10000;
    localparam logic [CNT_W-1:0]  RST_MIN_SAMPLES    = 16'd10;

    // One poll.
    typedef struct packed {
        logic [WORD_W-1:0] die0_word;
        logic [WORD_W-1:0] die1_word;
        logic [WORD_W-1:0] die2_word;
        logic [WORD_W-1:0] die3_word;
        logic              samples_valid;
        logic [TIME_W-1:0] time_seconds;
    } t_in;

    // One result.
    typedef struct packed {
        logic              stats_status;
        logic [UTIL_W-1:0] stats_min_bips;
        logic [UTIL_W-1:0] stats_max_bips;
        logic [UTIL_W-1:0] stats_avg_bips;
        logic [TIME_W-1:0] stats_time_seconds;
        logic              stats_updated;
        logic              sample_stored;
        logic              sample_rejected;
        logic              duplicate_seen;
    } t_out;

    // Per-poll sample outcome from the accumulator.
    typedef struct packed {
        logic dup;
        logic stored;
        logic rejected;
    } t_eval_flags;

endpackage

[hw/rtl/ptagg_div.sv]
// ----------------------------------------------------------------------------
// Shared restoring divider
// Produces one quotient bit per cycle for a 32-bit dividend and a 16-bit
// divisor; the number of steps is chosen per operation.
// ----------------------------------------------------------------------------
module ptagg_div (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic [ptagg_pkg::DIV_W-1:0]      i_dividend,
    input  logic [ptagg_pkg::UTIL_W-1:0]     i_divisor,
    input  logic [ptagg_pkg::DIV_STEP_W-1:0] i_steps,
    output logic                             o_done,
    output logic [ptagg_pkg::DIV_W-1:0]      o_quotient
);
    import ptagg_pkg::*;

    logic                  r_busy;
    logic                  r_done;
    logic [DIV_STEP_W-1:0] r_cnt;
    logic [DIV_W-1:0]      r_quo;
    logic [UTIL_W-1:0]     r_rem;
    logic [UTIL_W-1:0]     r_div;

    logic [UTIL_W:0]   w_trial;
    logic [UTIL_W:0]   w_diff;
    logic              w_ge;
    logic [UTIL_W-1:0] n_rem;

    // One restoring step: bring in the next dividend bit and try to subtract.
    always_comb begin
        w_trial = {r_rem, r_quo[DIV_W-1]};
        w_diff  = w_trial - {1'b0, r_div};
        w_ge    = (w_trial >= {1'b0, r_div});
        n_rem   = w_ge ? w_diff[UTIL_W-1:0] : w_trial[UTIL_W-1:0];
    end

    // Control and datapath registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_steps;
                r_quo  <= i_dividend;
                r_rem  <= '0;
                r_div  <= i_divisor;
            end else if (r_busy) begin
                r_quo <= {r_quo[DIV_W-2:0], w_ge};
                r_rem <= n_rem;
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == DIV_STEP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

[hw/rtl/ptagg_acc.sv]
// ----------------------------------------------------------------------------
// Sample evaluator and minute accumulators
// Checks the die counters for a repeat, selects the largest utilization,
// applies the limit and keeps sum, count, minimum and maximum.
// ----------------------------------------------------------------------------
module ptagg_acc #(
    parameter int MAX_DICE = 4
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_eval,
    input  logic                          i_clear,
    input  ptagg_pkg::t_in                i_item,
    input  logic [ptagg_pkg::DICE_W-1:0]  i_dice_in_use,
    input  logic [ptagg_pkg::UTIL_W-1:0]  i_max_valid,
    output ptagg_pkg::t_eval_flags        o_flags,
    output logic [ptagg_pkg::SUM_W-1:0]   o_sum,
    output logic [ptagg_pkg::CNT_W-1:0]   o_count,
    output logic [ptagg_pkg::UTIL_W-1:0]  o_min,
    output logic [ptagg_pkg::UTIL_W-1:0]  o_max
);
    import ptagg_pkg::*;

    logic [UTIL_W-1:0] r_last [MAX_DICE];
    logic [SUM_W-1:0]  r_sum;
    logic [CNT_W-1:0]  r_count;
    logic [UTIL_W-1:0] r_min;
    logic [UTIL_W-1:0] r_max;
    t_eval_flags       r_flags;

    logic [WORD_W-1:0] w_word [4];
    logic [DICE_W-1:0] w_neff;
    logic [UTIL_W-1:0] w_largest;
    logic [SUM_W:0]    w_sum_wide;
    t_eval_flags       n_flags;

    assign w_word[0] = i_item.die0_word;
    assign w_word[1] = i_item.die1_word;
    assign w_word[2] = i_item.die2_word;
    assign w_word[3] = i_item.die3_word;

    // Examine the active dice: any repeated counter marks a duplicate poll.
    always_comb begin
        w_neff    = (i_dice_in_use > DICE_W'(MAX_DICE)) ? DICE_W'(MAX_DICE) : i_dice_in_use;
        n_flags   = '0;
        w_largest = '0;
        for (int d = 0; d < MAX_DICE; d++) begin
            if (i_item.samples_valid && (DICE_W'(d) < w_neff)) begin
                if (w_word[d][WORD_W-1:UTIL_W] == r_last[d]) begin
                    n_flags.dup = 1'b1;
                end else if (w_word[d][UTIL_W-1:0] > w_largest) begin
                    w_largest = w_word[d][UTIL_W-1:0];
                end
            end
        end
        n_flags.rejected = i_item.samples_valid && !n_flags.dup && (w_largest > i_max_valid);
        n_flags.stored   = i_item.samples_valid && !n_flags.dup && !n_flags.rejected;
        w_sum_wide       = {1'b0, r_sum} + {{(SUM_W-UTIL_W+1){1'b0}}, w_largest};
    end

    // Accumulators, saved counters and the outcome of the last evaluation.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum   <= '0;
            r_count <= '0;
            r_min   <= RST_MAX_VALID_BIPS;
            r_max   <= '0;
            r_flags <= '0;
            for (int d = 0; d < MAX_DICE; d++) begin
                r_last[d] <= '0;
            end
        end else if (i_clear) begin
            r_sum   <= '0;
            r_count <= '0;
            r_min   <= i_max_valid;
            r_max   <= '0;
        end else if (i_eval) begin
            r_flags <= n_flags;
            if (n_flags.stored) begin
                r_sum <= w_sum_wide[SUM_W] ? SUM_SAT : w_sum_wide[SUM_W-1:0];
                if (r_count != CNT_SAT) begin
                    r_count <= r_count + 1'b1;
                end
                if (w_largest < r_min) begin
                    r_min <= w_largest;
                end
                if (w_largest > r_max) begin
                    r_max <= w_largest;
                end
                for (int d = 0; d < MAX_DICE; d++) begin
                    if (DICE_W'(d) < w_neff) begin
                        r_last[d] <= w_word[d][WORD_W-1:UTIL_W];
                    end
                end
            end
        end
    end

    assign o_flags = r_flags;
    assign o_sum   = r_sum;
    assign o_count = r_count;
    assign o_min   = r_min;
    assign o_max   = r_max;

endmodule

[hw/rtl/power_telemetry_aggregator_unit.sv]
// ----------------------------------------------------------------------------
// Power telemetry aggregator
// Folds per-die utilization polls into per-minute min, max and average stats.
// ----------------------------------------------------------------------------
// Each accepted poll is evaluated and its minute number formed; a poll within
// the current minute goes straight to the output, and one that opens a new
// minute first publishes no-data or valid stats, running the divider for valid
// stats from a nonzero sample count. The minute number comes from a reciprocal
// multiplication done in two steps, and the average from one shared restoring
// divider that yields one quotient bit per cycle over 32 steps. The input
// channel stalls while a poll is in progress; the finished result sits in an
// output register, so the next poll may be taken while it waits. A result that
// cannot leave because the previous one is still stalled holds the sequencer
// until the output register frees. Configuration writes are always ready.
// ----------------------------------------------------------------------------
module power_telemetry_aggregator_unit #(
    parameter int MAX_DICE = 4
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  ptagg_pkg::t_in                      i_in,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output ptagg_pkg::t_out                     o_out,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [ptagg_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [ptagg_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import ptagg_pkg::*;

    // Sequencer states.
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_EVAL   = 3'd1;
    localparam logic [2:0] S_MUL    = 3'd2;
    localparam logic [2:0] S_MINUTE = 3'd3;
    localparam logic [2:0] S_AVG    = 3'd4;
    localparam logic [2:0] S_PUB    = 3'd5;
    localparam logic [2:0] S_DONE   = 3'd6;

    logic [2:0]          r_state;
    t_in                 r_item;
    logic [DICE_W-1:0]   r_dice_in_use;
    logic [UTIL_W-1:0]   r_max_valid;
    logic [CNT_W-1:0]    r_min_samples;
    logic [PROD_W-1:0]   r_prod;
    logic                r_updated;
    logic                r_pub_status;
    logic [UTIL_W-1:0]   r_pub_min;
    logic [UTIL_W-1:0]   r_pub_max;
    logic [UTIL_W-1:0]   r_pub_avg;
    logic [TIME_W-1:0]   r_pub_time;
    logic [MINUTE_W-1:0] r_pub_minute;
    logic                r_out_valid;
    t_out                r_out;

    logic                  w_acc_eval;
    logic                  w_acc_clear;
    t_eval_flags           w_flags;
    logic [SUM_W-1:0]      w_sum;
    logic [CNT_W-1:0]      w_count;
    logic [UTIL_W-1:0]     w_min;
    logic [UTIL_W-1:0]     w_max;
    logic                  w_div_start;
    logic [DIV_W-1:0]      w_div_dividend;
    logic [UTIL_W-1:0]     w_div_divisor;
    logic [DIV_STEP_W-1:0] w_div_steps;
    logic                  w_div_done;
    logic [DIV_W-1:0]      w_div_quo;
    logic                  w_enough;
    logic [UTIL_W-1:0]     w_avg_clip;
    logic                  w_out_free;
    logic                  w_out_load;
    logic [TQ_W-1:0]       w_tq;
    logic [RECIP_HI_W-1:0] w_mul_k;
    logic [MUL_W-1:0]      w_mul;
    logic [MINUTE_W-1:0]   w_minute;
    logic                  w_new_minute;

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;
    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign w_out_load  = (r_state == S_DONE) && w_out_free;

    // Accumulators and sample evaluation.
    ptagg_acc #(
        .MAX_DICE (MAX_DICE)
    ) u_acc (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_eval        (w_acc_eval),
        .i_clear       (w_acc_clear),
        .i_item        (r_item),
        .i_dice_in_use (r_dice_in_use),
        .i_max_valid   (r_max_valid),
        .o_flags       (w_flags),
        .o_sum         (w_sum),
        .o_count       (w_count),
        .o_min         (w_min),
        .o_max         (w_max)
    );

    // Shared divider for the average.
    ptagg_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_div_dividend),
        .i_divisor  (w_div_divisor),
        .i_steps    (w_div_steps),
        .o_done     (w_div_done),
        .o_quotient (w_div_quo)
    );

    // Minute multiplier, sequencer strobes and divider operands.
    always_comb begin
        w_tq           = r_item.time_seconds[TIME_W-1:TIME_W-TQ_W];
        w_mul_k        = (r_state == S_EVAL) ? RECIP_HI : RECIP_LO;
        w_mul          = {{RECIP_HI_W{1'b0}}, w_tq} * {{TQ_W{1'b0}}, w_mul_k};
        w_minute       = r_prod[PROD_W-1:RECIP_SHIFT];
        w_new_minute   = (w_minute != r_pub_minute);
        w_enough       = (w_count >= r_min_samples);
        w_avg_clip     = (w_div_quo[SUM_W-1:UTIL_W] != '0) ? UTIL_SAT : w_div_quo[UTIL_W-1:0];
        w_acc_eval     = (r_state == S_EVAL);
        w_acc_clear    = (r_state == S_PUB);
        w_div_start    = (r_state == S_MINUTE) && w_new_minute && w_enough &&
                         (w_count != '0);
        w_div_dividend = w_sum;
        w_div_divisor  = w_count;
        w_div_steps    = AVG_STEPS;
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dice_in_use <= RST_DICE_IN_USE;
            r_max_valid   <= RST_MAX_VALID_BIPS;
            r_min_samples <= RST_MIN_SAMPLES;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_DICE_IN_USE:    r_dice_in_use <= i_cfg_data[DICE_W-1:0];
                CFG_MAX_VALID_BIPS: r_max_valid   <= i_cfg_data[UTIL_W-1:0];
                CFG_MIN_SAMPLES:    r_min_samples <= i_cfg_data[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    // Poll sequencer, published stats and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_updated    <= 1'b0;
            r_pub_status <= 1'b0;
            r_pub_min    <= '0;
            r_pub_max    <= '0;
            r_pub_avg    <= '0;
            r_pub_time   <= '0;
            r_pub_minute <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_item  <= i_in;
                        r_state <= S_EVAL;
                    end
                end
                S_EVAL: begin
                    // High part of the reciprocal product.
                    r_prod  <= {{(PROD_W-MUL_W){1'b0}}, w_mul};
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    // Low part completes the product; the minute is its top bits.
                    r_prod  <= {r_prod[MUL_W-1:0], {RECIP_LO_W{1'b0}}} +
                               {{(PROD_W-MUL_W){1'b0}}, w_mul};
                    r_state <= S_MINUTE;
                end
                S_MINUTE: begin
                    if (!w_new_minute) begin
                        r_updated <= 1'b0;
                        r_state   <= S_DONE;
                    end else begin
                        r_updated <= 1'b1;
                        r_state   <= (w_enough && (w_count != '0)) ? S_AVG : S_PUB;
                    end
                end
                S_AVG: begin
                    if (w_div_done) begin
                        r_state <= S_PUB;
                    end
                end
                S_PUB: begin
                    // Publish this minute's stats; the accumulators clear now.
                    r_pub_status <= w_enough;
                    r_pub_min    <= w_enough ? w_min : '0;
                    r_pub_max    <= w_enough ? w_max : '0;
                    r_pub_avg    <= (w_enough && (w_count != '0)) ? w_avg_clip : '0;
                    r_pub_time   <= r_item.time_seconds;
                    r_pub_minute <= w_minute;
                    r_state      <= S_DONE;
                end
                S_DONE: begin
                    if (w_out_free) begin
                        r_out.stats_status       <= r_pub_status;
                        r_out.stats_min_bips     <= r_pub_min;
                        r_out.stats_max_bips     <= r_pub_max;
                        r_out.stats_avg_bips     <= r_pub_avg;
                        r_out.stats_time_seconds <= r_pub_time;
                        r_out.stats_updated      <= r_updated;
                        r_out.sample_stored      <= w_flags.stored;
                        r_out.sample_rejected    <= w_flags.rejected;
                        r_out.duplicate_seen     <= w_flags.dup;
                        r_state                  <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule
